>>> hw/rtl/tgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_pkg
// Shared types and constants of the touch gesture tracker.
// ----------------------------------------------------------------------------
package tgt_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_THRESH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION   = 3'd4;

    localparam logic [15:0] SLIDE_THRESH_RST  = 16'd10;
    localparam logic [15:0] TAP_WINDOW_RST    = 16'd250;
    localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd320;
    localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd480;
    localparam logic        ORIENTATION_RST   = 1'b0;

    localparam logic [2:0] G_NONE      = 3'd0;
    localparam logic [2:0] G_DOWN      = 3'd1;
    localparam logic [2:0] G_UP        = 3'd2;
    localparam logic [2:0] G_SLIDE     = 3'd3;
    localparam logic [2:0] G_SLIDE_END = 3'd4;

    localparam logic [14:0] TAP_MAX = 15'h7FFF;

    typedef struct packed {
        logic [15:0] slide_thresh;
        logic [15:0] tap_window_ms;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic        orientation_mode;
    } cfg_t;

    typedef struct packed {
        logic        event_pending;
        logic [31:0] now_ms;
        logic        touch_present;
        logic        is_contact;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
    } poll_t;

    typedef struct packed {
        logic [2:0]  gesture;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] delta_x;
        logic [15:0] delta_y;
        logic [14:0] taps;
    } rec_t;

endpackage

>>> hw/rtl/tgt_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_map
// Maps raw panel coordinates to screen coordinates (quarter turn or invert).
// ----------------------------------------------------------------------------
module tgt_map (
    input  tgt_pkg::cfg_t cfg,
    input  logic [15:0]   raw_x,
    input  logic [15:0]   raw_y,
    output logic [15:0]   scr_x,
    output logic [15:0]   scr_y
);

    always_comb begin
        if (cfg.orientation_mode) begin
            scr_x = cfg.screen_width - raw_x;
            scr_y = cfg.screen_height - raw_y;
        end else begin
            scr_x = cfg.screen_width - 16'd1 - raw_y;
            scr_y = raw_x;
        end
    end

endmodule

>>> hw/rtl/tgt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_core
// Gesture state, tap timing and the record produced for each poll.
// ----------------------------------------------------------------------------
module tgt_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  tgt_pkg::poll_t poll,
    input  tgt_pkg::cfg_t  cfg,
    input  logic [15:0]    scr_x,
    input  logic [15:0]    scr_y,
    output tgt_pkg::rec_t  emit_rec
);

    tgt_pkg::rec_t rec_reg, rec_next, rec_v;
    logic [14:0]   tap_cnt_reg, tap_cnt_next;
    logic [31:0]   press_start_reg, press_start_next;
    logic [31:0]   last_tap_reg, last_tap_next;
    logic          armed_reg, armed_next;

    logic signed [17:0] dx, dy, rng, neg_rng;
    logic               big_move;
    logic [31:0]        press_age, tap_gap;
    logic [31:0]        window32;

    assign dx        = $signed({2'b00, scr_x}) - $signed({2'b00, rec_reg.pos_x});
    assign dy        = $signed({2'b00, scr_y}) - $signed({2'b00, rec_reg.pos_y});
    assign rng       = $signed({2'b00, cfg.slide_thresh});
    assign neg_rng   = -rng;
    assign big_move  = (dx >= rng) || (dx <= neg_rng) || (dy >= rng) || (dy <= neg_rng);
    assign press_age = poll.now_ms - press_start_reg;
    assign tap_gap   = poll.now_ms - last_tap_reg;
    assign window32  = {16'd0, cfg.tap_window_ms};

    always_comb begin
        rec_v            = rec_reg;
        tap_cnt_next     = tap_cnt_reg;
        press_start_next = press_start_reg;
        last_tap_next    = last_tap_reg;
        armed_next       = armed_reg;
        if (poll.event_pending) begin
            rec_v.taps = '0;
            if (poll.touch_present) begin
                if (poll.is_contact) begin
                    rec_v.pos_x = scr_x;
                    rec_v.pos_y = scr_y;
                    case (rec_reg.gesture)
                        tgt_pkg::G_DOWN: begin
                            if (big_move) begin
                                rec_v.gesture = tgt_pkg::G_SLIDE;
                                rec_v.delta_x = dx[15:0];
                                rec_v.delta_y = dy[15:0];
                            end else begin
                                rec_v.delta_x = '0;
                                rec_v.delta_y = '0;
                            end
                        end
                        tgt_pkg::G_SLIDE: begin
                            rec_v.delta_x = dx[15:0];
                            rec_v.delta_y = dy[15:0];
                        end
                        default: begin
                            rec_v.start_x = scr_x;
                            rec_v.start_y = scr_y;
                            rec_v.gesture = tgt_pkg::G_DOWN;
                        end
                    endcase
                end
                if (rec_v.gesture == tgt_pkg::G_DOWN && !armed_reg) begin
                    press_start_next = poll.now_ms;
                    armed_next       = 1'b1;
                end
            end else if (rec_reg.gesture == tgt_pkg::G_DOWN) begin
                rec_v.gesture = tgt_pkg::G_UP;
                if (press_age <= window32) begin
                    if (tap_gap > window32) begin
                        tap_cnt_next = 15'd1;
                    end else if (tap_cnt_reg < tgt_pkg::TAP_MAX) begin
                        tap_cnt_next = tap_cnt_reg + 15'd1;
                    end
                    rec_v.taps    = tap_cnt_next;
                    last_tap_next = poll.now_ms;
                end
                armed_next = 1'b0;
            end else begin
                tap_cnt_next  = '0;
                rec_v.gesture = tgt_pkg::G_SLIDE_END;
            end
        end

        emit_rec = rec_v;
        rec_next = rec_v;
        if (poll.event_pending) begin
            rec_next.delta_x = '0;
            rec_next.delta_y = '0;
            if (rec_v.gesture == tgt_pkg::G_UP || rec_v.gesture == tgt_pkg::G_SLIDE_END) begin
                rec_next.gesture = tgt_pkg::G_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg         <= '0;
            tap_cnt_reg     <= '0;
            press_start_reg <= '0;
            last_tap_reg    <= '0;
            armed_reg       <= 1'b0;
        end else if (fire) begin
            rec_reg         <= rec_next;
            tap_cnt_reg     <= tap_cnt_next;
            press_start_reg <= press_start_next;
            last_tap_reg    <= last_tap_next;
            armed_reg       <= armed_next;
        end
    end

endmodule

>>> hw/rtl/touch_gesture_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_tracker
// Turns touch panel polls into gesture records, one record per poll word.
//
// Input stream (s_): one word per panel poll. Output stream (m_): one gesture
// record word per poll, in order. Config channel (cfg_): register writes by
// index, always ready; write only while no poll is in flight.
// An accepted word goes into the input register; its record then goes into
// the result register, which drives m_. Throughput: one word per cycle while
// m_tready is high; the gesture update is combinational logic between them.
// Reset: synchronous, active low; clears both stream stages, the gesture
// record and tap timing, and loads the register defaults.
// Stall: a held result keeps the result register; the input register still
// takes a word if empty, after which s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module touch_gesture_tracker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,    // now_ms[31:0], raw_x[47:32], raw_y[63:48]
    input  logic [2:0]   s_tuser,    // event_pending[0], touch_present[1], is_contact[2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,    // pos_x, pos_y, start_x, start_y, delta_x,
                                     // delta_y (16 b each), taps[110:96], zero pad
    output logic [2:0]   m_tuser,    // gesture
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [tgt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]  cfg_data
);

    tgt_pkg::cfg_t  cfg_reg;
    tgt_pkg::poll_t in_reg;
    tgt_pkg::rec_t  out_reg, emit_rec;
    logic           in_valid_reg, out_valid_reg;
    logic           out_free, fire;
    logic [15:0]    scr_x, scr_y;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slide_thresh     <= tgt_pkg::SLIDE_THRESH_RST;
            cfg_reg.tap_window_ms    <= tgt_pkg::TAP_WINDOW_RST;
            cfg_reg.screen_width     <= tgt_pkg::SCREEN_WIDTH_RST;
            cfg_reg.screen_height    <= tgt_pkg::SCREEN_HEIGHT_RST;
            cfg_reg.orientation_mode <= tgt_pkg::ORIENTATION_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tgt_pkg::CFG_SLIDE_THRESH:  cfg_reg.slide_thresh     <= cfg_data;
                tgt_pkg::CFG_TAP_WINDOW:    cfg_reg.tap_window_ms    <= cfg_data;
                tgt_pkg::CFG_SCREEN_WIDTH:  cfg_reg.screen_width     <= cfg_data;
                tgt_pkg::CFG_SCREEN_HEIGHT: cfg_reg.screen_height    <= cfg_data;
                tgt_pkg::CFG_ORIENTATION:   cfg_reg.orientation_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.event_pending <= s_tuser[0];
            in_reg.touch_present <= s_tuser[1];
            in_reg.is_contact    <= s_tuser[2];
            in_reg.now_ms        <= s_tdata[31:0];
            in_reg.raw_x         <= s_tdata[47:32];
            in_reg.raw_y         <= s_tdata[63:48];
        end
    end

    tgt_map u_map (
        .cfg   (cfg_reg),
        .raw_x (in_reg.raw_x),
        .raw_y (in_reg.raw_y),
        .scr_x (scr_x),
        .scr_y (scr_y)
    );

    tgt_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .poll     (in_reg),
        .cfg      (cfg_reg),
        .scr_x    (scr_x),
        .scr_y    (scr_y),
        .emit_rec (emit_rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= emit_rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.gesture;
    assign m_tdata  = {1'b0, out_reg.taps, out_reg.delta_y, out_reg.delta_x,
                       out_reg.start_y, out_reg.start_x, out_reg.pos_y, out_reg.pos_x};

endmodule

>>> hw/rtl/tgt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_checker
// Port-level checks of the gesture tracker result stream.
// ----------------------------------------------------------------------------
module tgt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [2:0]   m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_delta_only_slide: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != tgt_pkg::G_SLIDE |-> m_tdata[95:64] == 32'd0)
        else $error("nonzero delta outside a slide");

    a_taps_not_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tgt_pkg::G_DOWN || m_tuser == tgt_pkg::G_SLIDE ||
                     m_tuser == tgt_pkg::G_SLIDE_END) |-> m_tdata[110:96] == 15'd0)
        else $error("tap count reported without a release");

endmodule

bind touch_gesture_tracker tgt_checker u_tgt_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch gesture tracker. A short table of polls
// and register writes comes first, then random press, slide and tap sequences
// mixed with noise under several register settings, then a run of quick taps
// that counts up the tap total. Every record is checked field by field
// against a gesture tracker kept in the bench or a record given in the table.
// Both streams idle at random; the record side once holds off to stall input.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT_CYC  = 3_000_000;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_CYC   = 300;
    localparam int MIX_ITEMS  = 230;
    localparam int TAP_RUN    = 60;

    typedef enum logic {ROW_POLL, ROW_REG} row_kind_e;
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    typedef struct {
        row_kind_e                     kind;
        logic [tgt_pkg::CFG_IDX_W-1:0] idx;
        logic [15:0]                   val;
        tgt_pkg::poll_t                poll;
        bit                            typed;
        tgt_pkg::rec_t                 want;
    } step_row_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [63:0]                   s_tdata   = '0;
    logic [2:0]                    s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [111:0]                  m_tdata;
    logic [2:0]                    m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tgt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                   cfg_data  = '0;

    touch_gesture_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // tracker kept by the bench
    tgt_pkg::cfg_t cfg_m;
    logic [2:0]    trk_gest;
    logic [15:0]   trk_px, trk_py, trk_ox, trk_oy, trk_mx, trk_my;
    logic [14:0]   trk_taps, trk_cnt;
    logic [31:0]   trk_press_t, trk_last_tap;
    bit            trk_armed;

    tgt_pkg::rec_t gesture_q[$];
    int            n_polls;
    int            n_records = 0;
    int            n_err     = 0;
    int            cyc       = 0;
    int            burst_left = 0;
    logic [31:0]   clk_ms = '0;

    function automatic tgt_pkg::rec_t cur_rec();
        tgt_pkg::rec_t r;
        r.gesture = trk_gest;
        r.pos_x   = trk_px;
        r.pos_y   = trk_py;
        r.start_x = trk_ox;
        r.start_y = trk_oy;
        r.delta_x = trk_mx;
        r.delta_y = trk_my;
        r.taps    = trk_taps;
        return r;
    endfunction

    task automatic track_reset();
        cfg_m.slide_thresh     = tgt_pkg::SLIDE_THRESH_RST;
        cfg_m.tap_window_ms    = tgt_pkg::TAP_WINDOW_RST;
        cfg_m.screen_width     = tgt_pkg::SCREEN_WIDTH_RST;
        cfg_m.screen_height    = tgt_pkg::SCREEN_HEIGHT_RST;
        cfg_m.orientation_mode = tgt_pkg::ORIENTATION_RST;
        trk_gest = tgt_pkg::G_NONE;
        {trk_px, trk_py, trk_ox, trk_oy, trk_mx, trk_my} = '0;
        trk_taps = '0;
        trk_cnt = '0;
        trk_press_t = '0;
        trk_last_tap = '0;
        trk_armed = 1'b0;
    endtask

    task automatic track_poll(input tgt_pkg::poll_t p, output tgt_pkg::rec_t r);
        logic [15:0] sx, sy;
        logic [31:0] held, gap;
        int ax, ay, cx, cy, dx, dy, rng;
        if (!p.event_pending) begin
            r = cur_rec();
            return;
        end
        trk_taps = '0;
        if (p.touch_present) begin
            if (p.is_contact) begin
                if (cfg_m.orientation_mode) begin
                    sx = cfg_m.screen_width - p.raw_x;
                    sy = cfg_m.screen_height - p.raw_y;
                end else begin
                    sx = cfg_m.screen_width - 16'd1 - p.raw_y;
                    sy = p.raw_x;
                end
                ax = sx;
                ay = sy;
                cx = trk_px;
                cy = trk_py;
                dx = ax - cx;
                dy = ay - cy;
                rng = cfg_m.slide_thresh;
                trk_px = sx;
                trk_py = sy;
                case (trk_gest)
                    tgt_pkg::G_NONE, tgt_pkg::G_UP, tgt_pkg::G_SLIDE_END: begin
                        trk_ox = sx;
                        trk_oy = sy;
                        trk_gest = tgt_pkg::G_DOWN;
                    end
                    tgt_pkg::G_DOWN: begin
                        if (dx >= rng || dx <= -rng || dy >= rng || dy <= -rng) begin
                            trk_gest = tgt_pkg::G_SLIDE;
                            trk_mx = dx[15:0];
                            trk_my = dy[15:0];
                        end else begin
                            trk_mx = '0;
                            trk_my = '0;
                        end
                    end
                    tgt_pkg::G_SLIDE: begin
                        trk_mx = dx[15:0];
                        trk_my = dy[15:0];
                    end
                    default: ;
                endcase
            end
            if (trk_gest == tgt_pkg::G_DOWN && !trk_armed) begin
                trk_press_t = p.now_ms;
                trk_armed = 1'b1;
            end
        end else if (trk_gest == tgt_pkg::G_DOWN) begin
            trk_gest = tgt_pkg::G_UP;
            held = p.now_ms - trk_press_t;
            if (held <= {16'd0, cfg_m.tap_window_ms}) begin
                gap = p.now_ms - trk_last_tap;
                if (gap > {16'd0, cfg_m.tap_window_ms})
                    trk_cnt = 15'd1;
                else if (trk_cnt < tgt_pkg::TAP_MAX)
                    trk_cnt = trk_cnt + 15'd1;
                trk_taps = trk_cnt;
                trk_last_tap = p.now_ms;
            end
            trk_armed = 1'b0;
        end else begin
            trk_cnt = '0;
            trk_gest = tgt_pkg::G_SLIDE_END;
        end
        r = cur_rec();
        trk_mx = '0;
        trk_my = '0;
        if (trk_gest == tgt_pkg::G_UP || trk_gest == tgt_pkg::G_SLIDE_END)
            trk_gest = tgt_pkg::G_NONE;
    endtask

    function automatic tgt_pkg::poll_t poll_of(logic ev, logic [31:0] now, logic tp,
                                               logic ct, logic [15:0] rx, logic [15:0] ry);
        tgt_pkg::poll_t p;
        p.event_pending = ev;
        p.now_ms        = now;
        p.touch_present = tp;
        p.is_contact    = ct;
        p.raw_x         = rx;
        p.raw_y         = ry;
        return p;
    endfunction

    function automatic tgt_pkg::rec_t rec_of(logic [2:0] g, logic [15:0] px, logic [15:0] py,
                                             logic [15:0] ox, logic [15:0] oy);
        tgt_pkg::rec_t r;
        r = '0;
        r.gesture = g;
        r.pos_x   = px;
        r.pos_y   = py;
        r.start_x = ox;
        r.start_y = oy;
        return r;
    endfunction

    function automatic tgt_pkg::cfg_t mk_cfg(logic [15:0] sr, logic [15:0] tw, logic [15:0] w,
                                             logic [15:0] h, logic o);
        tgt_pkg::cfg_t c;
        c.slide_thresh     = sr;
        c.tap_window_ms    = tw;
        c.screen_width     = w;
        c.screen_height    = h;
        c.orientation_mode = o;
        return c;
    endfunction

    function automatic step_row_t poll_row(logic ev, logic [31:0] now, logic tp, logic ct,
                                           logic [15:0] rx, logic [15:0] ry);
        step_row_t s;
        s.kind  = ROW_POLL;
        s.idx   = '0;
        s.val   = '0;
        s.poll  = poll_of(ev, now, tp, ct, rx, ry);
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic step_row_t known(step_row_t s, tgt_pkg::rec_t w);
        s.typed = 1'b1;
        s.want  = w;
        return s;
    endfunction

    function automatic step_row_t reg_row(logic [tgt_pkg::CFG_IDX_W-1:0] idx,
                                          logic [15:0] val);
        step_row_t s;
        s = poll_row(1'b0, '0, 1'b0, 1'b0, '0, '0);
        s.kind = ROW_REG;
        s.idx  = idx;
        s.val  = val;
        return s;
    endfunction

    task automatic send_poll(input tgt_pkg::poll_t p, input bit typed = 1'b0,
                             input tgt_pkg::rec_t want = '0);
        tgt_pkg::rec_t pred;
        int gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {p.raw_y, p.raw_x, p.now_ms};
        s_tuser  <= {p.is_contact, p.touch_present, p.event_pending};
        do @(posedge aclk); while (!s_tready);
        track_poll(p, pred);
        gesture_q.push_back(typed ? want : pred);
        n_polls++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (gesture_q.size() != 0) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [tgt_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            tgt_pkg::CFG_SLIDE_THRESH:  cfg_m.slide_thresh     = val;
            tgt_pkg::CFG_TAP_WINDOW:    cfg_m.tap_window_ms    = val;
            tgt_pkg::CFG_SCREEN_WIDTH:  cfg_m.screen_width     = val;
            tgt_pkg::CFG_SCREEN_HEIGHT: cfg_m.screen_height    = val;
            tgt_pkg::CFG_ORIENTATION:   cfg_m.orientation_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input tgt_pkg::cfg_t c);
        drain();
        reg_write(tgt_pkg::CFG_SLIDE_THRESH, c.slide_thresh);
        reg_write(tgt_pkg::CFG_TAP_WINDOW, c.tap_window_ms);
        reg_write(tgt_pkg::CFG_SCREEN_WIDTH, c.screen_width);
        reg_write(tgt_pkg::CFG_SCREEN_HEIGHT, c.screen_height);
        reg_write(tgt_pkg::CFG_ORIENTATION, {15'($urandom), c.orientation_mode});
        // unmapped index, must leave every register alone
        reg_write(tgt_pkg::CFG_IDX_W'($urandom_range(tgt_pkg::CFG_ORIENTATION + 1,
                                                      (1 << tgt_pkg::CFG_IDX_W) - 1)),
                  16'($urandom));
    endtask

    // presses with random drift and timing, mixed with noise and broken sequences
    task automatic play_mix(input int n);
        int stop, pick, k, jit, win;
        logic [15:0] bx, by;
        stop = n_polls + n;
        win = cfg_m.tap_window_ms;
        while (n_polls < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                clk_ms = $urandom;
            else if (pick < 4)
                clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * win + 2);
            if (pick < 70) begin
                k = $urandom_range(1, 6);
                bx = 16'($urandom);
                by = 16'($urandom);
                jit = $urandom_range(0, 1) ? int'(cfg_m.slide_thresh) + 2 : 3;
                for (int i = 0; i < k; i++) begin
                    clk_ms += $urandom_range(0, win / (k + 1) + 1);
                    bx += 16'($urandom_range(0, 2 * jit) - jit);
                    by += 16'($urandom_range(0, 2 * jit) - jit);
                    send_poll(poll_of(1'b1, clk_ms, 1'b1, 1'b1, bx, by));
                    if ($urandom_range(0, 5) == 0)
                        send_poll(poll_of(1'($urandom_range(0, 1)), clk_ms, 1'b1, 1'b0,
                                          16'($urandom), 16'($urandom)));
                end
                clk_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * win + 2)
                                                       : $urandom_range(0, win / 2 + 1);
                send_poll(poll_of(1'b1, clk_ms, 1'b0, 1'($urandom_range(0, 1)),
                                  16'($urandom), 16'($urandom)));
                clk_ms += $urandom_range(0, win + win / 2 + 2);
            end else if (pick < 85) begin
                send_poll(poll_of(1'($urandom_range(0, 1)), $urandom,
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  16'($urandom), 16'($urandom)));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    clk_ms += $urandom_range(0, win + 2);
                    send_poll(poll_of(1'($urandom_range(0, 1)), clk_ms, 1'b0,
                                      1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom)));
                end
            end
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            n_err++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : record_mon
        tgt_pkg::rec_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.gesture = m_tuser;
            got.pos_x   = m_tdata[15:0];
            got.pos_y   = m_tdata[31:16];
            got.start_x = m_tdata[47:32];
            got.start_y = m_tdata[63:48];
            got.delta_x = m_tdata[79:64];
            got.delta_y = m_tdata[95:80];
            got.taps    = m_tdata[110:96];
            n_records <= n_records + 1;
            if (gesture_q.size() == 0) begin
                n_err++;
                $error("record word with no pending expectation");
            end else begin
                want = gesture_q.pop_front();
                check_field("gesture", want.gesture, got.gesture);
                check_field("pos_x",   want.pos_x,   got.pos_x);
                check_field("pos_y",   want.pos_y,   got.pos_y);
                check_field("start_x", want.start_x, got.start_x);
                check_field("start_y", want.start_y, got.start_y);
                check_field("delta_x", want.delta_x, got.delta_x);
                check_field("delta_y", want.delta_y, got.delta_y);
                check_field("taps",    want.taps,    got.taps);
            end
        end
    end

    rx_mode_e rx_mode   = RX_FREE;
    int       rx_left   = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_records >= HOLD_AT) begin
            // long hold-off so the input side fills and backs up
            hold_done <= 1'b1;
            hold_left <= HOLD_CYC;
            m_tready  <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_mode_e'($urandom_range(0, 3));
                rx_left <= $urandom_range(16, 128);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        step_row_t dir_tab[$];
        n_polls = 0;
        track_reset();

        dir_tab.push_back(known(poll_row(1'b0, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0),
                                rec_of(tgt_pkg::G_NONE, 16'd0, 16'd0, 16'd0, 16'd0)));
        dir_tab.push_back(known(poll_row(1'b1, 32'd50, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF),
                                rec_of(tgt_pkg::G_NONE, 16'd0, 16'd0, 16'd0, 16'd0)));
        dir_tab.push_back(known(poll_row(1'b1, 32'd100, 1'b1, 1'b1, 16'd0, 16'd0),
                                rec_of(tgt_pkg::G_DOWN, 16'd319, 16'd0, 16'd319, 16'd0)));
        dir_tab.push_back(poll_row(1'b0, 32'd110, 1'b1, 1'b1, 16'd1234, 16'd5678));
        dir_tab.push_back(poll_row(1'b1, 32'd120, 1'b1, 1'b1, 16'd0, 16'd5));
        dir_tab.push_back(poll_row(1'b1, 32'd150, 1'b0, 1'b0, 16'd0, 16'd0));
        dir_tab.push_back(poll_row(1'b1, 32'd300, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
        dir_tab.push_back(poll_row(1'b1, 32'd310, 1'b1, 1'b1, 16'hFFF0, 16'hFFFF));
        dir_tab.push_back(poll_row(1'b1, 32'd320, 1'b1, 1'b0, 16'd0, 16'd0));
        dir_tab.push_back(poll_row(1'b1, 32'd330, 1'b1, 1'b1, 16'hFFE0, 16'hFFF0));
        dir_tab.push_back(poll_row(1'b0, 32'd335, 1'b0, 1'b0, 16'd0, 16'd0));
        dir_tab.push_back(poll_row(1'b1, 32'd340, 1'b0, 1'b1, 16'd0, 16'd0));
        dir_tab.push_back(poll_row(1'b1, 32'd350, 1'b0, 1'b0, 16'd0, 16'd0));
        dir_tab.push_back(reg_row(tgt_pkg::CFG_ORIENTATION, 16'hFFFF));
        dir_tab.push_back(reg_row(tgt_pkg::CFG_SLIDE_THRESH, 16'd0));
        dir_tab.push_back(known(poll_row(1'b1, 32'd1000, 1'b1, 1'b1, 16'd0, 16'd0),
                                rec_of(tgt_pkg::G_DOWN, 16'd320, 16'd480, 16'd320, 16'd480)));
        dir_tab.push_back(poll_row(1'b1, 32'd1010, 1'b1, 1'b1, 16'd0, 16'd0));
        dir_tab.push_back(known(poll_row(1'b1, 32'd1020, 1'b0, 1'b0, 16'd0, 16'd0),
                                rec_of(tgt_pkg::G_SLIDE_END, 16'd320, 16'd480,
                                       16'd320, 16'd480)));
        dir_tab.push_back(reg_row(tgt_pkg::CFG_TAP_WINDOW, 16'd0));
        dir_tab.push_back(poll_row(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd400, 16'd600));
        dir_tab.push_back(poll_row(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 16'd0));
        dir_tab.push_back(poll_row(1'b1, 32'd0, 1'b1, 1'b1, 16'd400, 16'd600));
        dir_tab.push_back(poll_row(1'b1, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        dir_tab.push_back(reg_row(tgt_pkg::CFG_SCREEN_WIDTH, 16'd1));
        dir_tab.push_back(reg_row(tgt_pkg::CFG_SCREEN_HEIGHT, 16'hFFFF));
        dir_tab.push_back(poll_row(1'b1, 32'd5, 1'b1, 1'b1, 16'hFFFF, 16'd0));
        dir_tab.push_back(poll_row(1'b1, 32'd6, 1'b1, 1'b1, 16'd0, 16'hFFFF));
        dir_tab.push_back(poll_row(1'b0, 32'd7, 1'b0, 1'b0, 16'd0, 16'd0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                drain();
                reg_write(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                send_poll(dir_tab[i].poll, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        apply_cfg(mk_cfg(tgt_pkg::SLIDE_THRESH_RST, tgt_pkg::TAP_WINDOW_RST,
                         tgt_pkg::SCREEN_WIDTH_RST, tgt_pkg::SCREEN_HEIGHT_RST,
                         tgt_pkg::ORIENTATION_RST));
        play_mix(MIX_ITEMS);
        apply_cfg(mk_cfg(16'd0, 16'd0, 16'd1, 16'd1, 1'b1));
        play_mix(MIX_ITEMS);
        apply_cfg(mk_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        play_mix(MIX_ITEMS);
        apply_cfg(mk_cfg(16'd3, 16'd40, 16'd800, 16'd600, 1'b1));
        play_mix(MIX_ITEMS);
        repeat (2) begin
            apply_cfg(mk_cfg(16'($urandom_range(0, 40)), 16'($urandom_range(0, 600)),
                             16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                             1'($urandom_range(0, 1))));
            play_mix(MIX_ITEMS);
        end

        // back-to-back quick taps, the tap count climbs on every release
        apply_cfg(mk_cfg(16'hFFFF, 16'hFFFF, tgt_pkg::SCREEN_WIDTH_RST,
                         tgt_pkg::SCREEN_HEIGHT_RST, 1'b0));
        repeat (TAP_RUN) begin
            send_poll(poll_of(1'b1, clk_ms, 1'b1, 1'b1, 16'd100, 16'd100));
            send_poll(poll_of(1'b1, clk_ms, 1'b0, 1'b0, 16'd0, 16'd0));
        end
        send_poll(poll_of(1'b0, clk_ms, 1'b0, 1'b0, 16'd0, 16'd0));

        drain();
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (n_err == 0 && gesture_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tgt_pkg.sv
hw/rtl/tgt_map.sv
hw/rtl/tgt_core.sv
hw/rtl/touch_gesture_tracker.sv
hw/rtl/tgt_checker.sv
tb/tb.sv
